FILE: design/gtw_pkg.sv
// Package with shared types, constants and score tables of the GNSS trust weighting block.
package gtw_pkg;

  localparam int SCORE_W = 17;
  localparam int TRUST_W = 16;
  localparam int VAR_W = 28;
  localparam int T2_W = 32;
  localparam int NUM_W = 44;

  localparam int Cn0Span = 240;
  localparam int DopSpan = 80;
  localparam int EXP_DEPTH = 256;

  localparam logic [SCORE_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [TRUST_W-1:0] TRUST_FLOOR = 16'd197;

  typedef struct packed {
    logic [TRUST_W-1:0] trust;
    logic               spoof;
  } gtw_side_t;

  typedef logic [15:0] cn0_tab_t [0:Cn0Span-1];
  typedef logic [15:0] dop_tab_t [0:DopSpan-1];
  typedef logic [SCORE_W-1:0] exp_tab_t [0:EXP_DEPTH-1];

  function automatic cn0_tab_t build_cn0();
    cn0_tab_t tab;
    for (int i = 0; i < Cn0Span; i++) begin
      tab[i] = 16'((i * 65536) / Cn0Span);
    end
    return tab;
  endfunction

  function automatic dop_tab_t build_dop();
    dop_tab_t tab;
    for (int i = 0; i < DopSpan; i++) begin
      tab[i] = 16'((i * 65536) / DopSpan);
    end
    return tab;
  endfunction

  function automatic exp_tab_t build_exp();
    exp_tab_t tab;
    logic [63:0] v;
    v = 64'h1_0000_0000;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      tab[i] = SCORE_W'((v + 64'd32768) >> 16);
      v = (v * 64'd4062864982 + 64'h8000_0000) >> 32;
    end
    return tab;
  endfunction

  localparam cn0_tab_t CN0_TAB = build_cn0();
  localparam dop_tab_t DOP_TAB = build_dop();
  localparam exp_tab_t EXP_TAB = build_exp();

endpackage

FILE: design/gtw_div.sv
// Pipelined restoring divider giving the rounded variance quotient, one bit per stage.
module gtw_div import gtw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [NUM_W-1:0] num,
  input  logic [T2_W-1:0]  den,
  input  gtw_side_t        in_side,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAR_W-1:0] quo_out,
  output gtw_side_t        out_side
);

  logic             vld  [0:VAR_W];
  logic             en   [1:VAR_W+1];
  logic [T2_W-1:0]  rem  [0:VAR_W];
  logic [VAR_W-1:0] low  [0:VAR_W];
  logic [VAR_W-1:0] quo  [0:VAR_W];
  logic [T2_W-1:0]  dv   [0:VAR_W];
  gtw_side_t        side [0:VAR_W];

  assign vld[0]  = in_valid;
  assign rem[0]  = T2_W'(num[NUM_W-1:VAR_W]);
  assign low[0]  = num[VAR_W-1:0];
  assign quo[0]  = '0;
  assign dv[0]   = den;
  assign side[0] = in_side;

  always_comb begin
    en[VAR_W+1] = out_ready;
    for (int k = VAR_W; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready = en[1];

  for (genvar k = 1; k <= VAR_W; k++) begin : g_step
    logic [T2_W:0] trial;
    logic          ge;
    assign trial = {rem[k-1], low[k-1][VAR_W-1]};
    assign ge = trial >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem[k]  <= ge ? T2_W'(trial - {1'b0, dv[k-1]}) : trial[T2_W-1:0];
        low[k]  <= {low[k-1][VAR_W-2:0], 1'b0};
        quo[k]  <= {quo[k-1][VAR_W-2:0], ge};
        dv[k]   <= dv[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_valid = vld[VAR_W];
  assign quo_out   = quo[VAR_W];
  assign out_side  = side[VAR_W];

endmodule

FILE: design/gnss_trust_weighting_top.sv
// Top level of the GNSS trust weighting block: scores, trust product, variance and spoof flag.
// A fully pipelined block that takes one epoch per clock while the output is not stalled; the
// depth is set by the variance divider, which resolves one quotient bit per stage over 28 stages
// behind seven stages of table lookup, multiplies and scaling.
// Each stage holds its item while the stage after it is full, so a stall at the output fills
// the pipeline's bubbles before the input side stops taking requests.
module gnss_trust_weighting_top import gtw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cn0_level[9:0], sats_used[15:10], regional_sats[19:16], dilution[29:20],
  // innovation_chi2[45:30], doppler_residual[61:46], zero fill [63:62]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // trust_weight[15:0], meas_variance[43:16], spoof_flag[44], zero fill [47:45]
  output logic [47:0] m_tdata
);

  logic [9:0]         cn0_level;
  logic [5:0]         sats_used;
  logic [3:0]         regional_sats;
  logic [9:0]         dilution;
  logic [15:0]        innovation_chi2;
  logic signed [15:0] doppler_residual;

  assign cn0_level        = s_tdata[9:0];
  assign sats_used        = s_tdata[15:10];
  assign regional_sats    = s_tdata[19:16];
  assign dilution         = s_tdata[29:20];
  assign innovation_chi2  = s_tdata[45:30];
  assign doppler_residual = s_tdata[61:46];

  logic v1, v2, v3, v4, v5, v6, v7;
  logic en1, en2, en3, en4, en5, en6, en7;
  logic div_ready;

  logic [SCORE_W-1:0] cn0_score, sat_score, dop_score, exp_score;
  logic [12:0]        exp_idx;
  logic [2:0]         boost_m;
  logic               spoof_next;

  always_comb begin
    if (cn0_level <= 10'd400) begin
      cn0_score = '0;
    end else if (cn0_level >= 10'd640) begin
      cn0_score = ONE_Q16;
    end else begin
      cn0_score = SCORE_W'(CN0_TAB[8'(cn0_level - 10'd400)]);
    end
    if (sats_used <= 6'd4) begin
      sat_score = '0;
    end else if (sats_used >= 6'd8) begin
      sat_score = ONE_Q16;
    end else begin
      sat_score = SCORE_W'(sats_used - 6'd4) << 14;
    end
    if (dilution >= 10'd96) begin
      dop_score = '0;
    end else if (dilution <= 10'd16) begin
      dop_score = ONE_Q16;
    end else begin
      dop_score = SCORE_W'(DOP_TAB[7'(10'd96 - dilution)]);
    end
    exp_idx = innovation_chi2[15:3];
    if (exp_idx < 13'(EXP_DEPTH)) begin
      exp_score = EXP_TAB[exp_idx[7:0]];
    end else begin
      exp_score = '0;
    end
    boost_m = (regional_sats > 4'd4) ? 3'd4 : regional_sats[2:0];
    spoof_next = (cn0_level > 10'd560) && (sats_used >= 6'd5) &&
                 ((innovation_chi2 > 16'd400) || (doppler_residual > 16'sd80) ||
                  (doppler_residual < -16'sd80));
  end

  assign en7 = !v7 || div_ready;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
    end
  end

  logic [SCORE_W-1:0] s1_cn0, s1_sat, s1_dop, s1_exp;
  logic [SCORE_W-1:0] s2_p, s2_dop, s2_exp;
  logic [SCORE_W-1:0] s3_p, s3_exp;
  logic [SCORE_W-1:0] s4_p;
  logic [20:0]        s5_x;
  logic [TRUST_W-1:0] s6_trust;
  logic [T2_W-1:0]    s7_t2;
  logic [NUM_W-1:0]   s7_num;
  logic [2:0]         s1_m, s2_m, s3_m, s4_m;
  logic               s1_f, s2_f, s3_f, s4_f, s5_f, s6_f;
  gtw_side_t          s7_side;

  logic [2*SCORE_W-1:0] prod2, prod3, prod4;
  logic [21:0]          prod5;
  logic [37:0]          prod6;
  logic [16:0]          quot6;
  logic [TRUST_W-1:0]   t_floor;
  logic [T2_W-1:0]      t2_next;

  assign prod2 = s1_cn0 * s1_sat;
  assign prod3 = s2_p * s2_dop;
  assign prod4 = s3_p * s3_exp;
  assign prod5 = s4_p * (5'd20 + {2'b00, s4_m});
  assign prod6 = 19'(s5_x >> 2) * 19'd419431;
  assign quot6 = prod6[37:21];
  assign t_floor = (s6_trust < TRUST_FLOOR) ? TRUST_FLOOR : s6_trust;
  assign t2_next = t_floor * t_floor;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_cn0 <= cn0_score;
      s1_sat <= sat_score;
      s1_dop <= dop_score;
      s1_exp <= exp_score;
      s1_m   <= boost_m;
      s1_f   <= spoof_next;
    end
    if (en2) begin
      s2_p   <= prod2[32:16];
      s2_dop <= s1_dop;
      s2_exp <= s1_exp;
      s2_m   <= s1_m;
      s2_f   <= s1_f;
    end
    if (en3) begin
      s3_p   <= prod3[32:16];
      s3_exp <= s2_exp;
      s3_m   <= s2_m;
      s3_f   <= s2_f;
    end
    if (en4) begin
      s4_p <= prod4[32:16];
      s4_m <= s3_m;
      s4_f <= s3_f;
    end
    if (en5) begin
      s5_x <= prod5[20:0];
      s5_f <= s4_f;
    end
    if (en6) begin
      s6_trust <= (quot6 > 17'd65535) ? 16'hFFFF : quot6[15:0];
      s6_f     <= s5_f;
    end
    if (en7) begin
      s7_t2         <= t2_next;
      s7_num        <= (NUM_W'(9) << 40) + NUM_W'(t2_next >> 1);
      s7_side.trust <= s6_trust;
      s7_side.spoof <= s6_f;
    end
  end

  logic [VAR_W-1:0] variance;
  gtw_side_t        out_side;

  gtw_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .in_ready  (div_ready),
    .num       (s7_num),
    .den       (s7_t2),
    .in_side   (s7_side),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .quo_out   (variance),
    .out_side  (out_side)
  );

  assign m_tdata = {3'b000, out_side.spoof, variance, out_side.trust};

endmodule
